// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define AVD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that is checked in every cycle, reset included.
`define AVD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== rtl/core/avd_pkg.sv =====
`default_nettype none

package avd_pkg;

   localparam int ACT_W   = 16;
   localparam int SLOPE_W = 13;
   localparam int MODE_W  = 3;
   localparam int Q12_W   = 13;

   typedef logic [Q12_W-1:0] q12_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_STEP    = 3'd0,
      MODE_LINEAR  = 3'd1,
      MODE_RELU    = 3'd2,
      MODE_SIGMOID = 3'd3,
      MODE_TANH    = 3'd4
   } function_mode_type;

   localparam q12_type     Q12_ONE  = 13'd4096;
   localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
   localparam logic [63:0] Q30_HALF = 64'd1 << 29;

endpackage

`default_nettype wire

// ===== rtl/core/avd_req_if.sv =====
`default_nettype none

interface avd_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [avd_pkg::ACT_W-1:0]   pre_activation;

   modport source (output valid, output pre_activation, input ready);
   modport sink (input valid, input pre_activation, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/avd_rsp_if.sv =====
`default_nettype none

interface avd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [avd_pkg::ACT_W-1:0]   activation;
   logic [avd_pkg::SLOPE_W-1:0]        slope;

   modport source (output valid, output activation, output slope, input ready);
   modport sink (input valid, input activation, input slope, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/avd_sig_rom.sv =====
`default_nettype none

module avd_sig_rom #(
   parameter int TABLE_ENTRIES = 256
) (
   input  wire logic                                 clock,
   input  wire logic                                 rd_en,
   input  wire logic [$clog2(TABLE_ENTRIES+1)-1:0]   addr_a,
   input  wire logic [$clog2(TABLE_ENTRIES+1)-1:0]   addr_b,
   output      avd_pkg::q12_type                     data_a_ff,
   output      avd_pkg::q12_type                     data_b_ff
);

   localparam int DEPTH = TABLE_ENTRIES + 1;

   avd_pkg::q12_type rom_table [DEPTH];

   // Each sample is the logistic function at 16k/TABLE_ENTRIES, with e^-u built
   // from a truncated series of e^-(u/32) raised to the 32nd power by squaring.
   for (genvar k = 0; k < DEPTH; k++) begin : g_sample
      localparam logic [63:0] Y   = (64'(k) << 30) / 64'(2 * TABLE_ENTRIES);
      localparam logic [63:0] ONE = avd_pkg::Q30_ONE;
      localparam logic [63:0] T01 = ((ONE * Y) >> 30) / 64'd1;
      localparam logic [63:0] T02 = ((T01 * Y) >> 30) / 64'd2;
      localparam logic [63:0] T03 = ((T02 * Y) >> 30) / 64'd3;
      localparam logic [63:0] T04 = ((T03 * Y) >> 30) / 64'd4;
      localparam logic [63:0] T05 = ((T04 * Y) >> 30) / 64'd5;
      localparam logic [63:0] T06 = ((T05 * Y) >> 30) / 64'd6;
      localparam logic [63:0] T07 = ((T06 * Y) >> 30) / 64'd7;
      localparam logic [63:0] T08 = ((T07 * Y) >> 30) / 64'd8;
      localparam logic [63:0] T09 = ((T08 * Y) >> 30) / 64'd9;
      localparam logic [63:0] T10 = ((T09 * Y) >> 30) / 64'd10;
      localparam logic [63:0] T11 = ((T10 * Y) >> 30) / 64'd11;
      localparam logic [63:0] T12 = ((T11 * Y) >> 30) / 64'd12;
      localparam logic [63:0] T13 = ((T12 * Y) >> 30) / 64'd13;
      localparam logic [63:0] T14 = ((T13 * Y) >> 30) / 64'd14;
      localparam logic [63:0] T15 = ((T14 * Y) >> 30) / 64'd15;
      localparam logic [63:0] T16 = ((T15 * Y) >> 30) / 64'd16;
      localparam logic [63:0] T17 = ((T16 * Y) >> 30) / 64'd17;
      localparam logic [63:0] T18 = ((T17 * Y) >> 30) / 64'd18;
      localparam logic [63:0] T19 = ((T18 * Y) >> 30) / 64'd19;
      localparam logic [63:0] T20 = ((T19 * Y) >> 30) / 64'd20;
      localparam logic [63:0] T21 = ((T20 * Y) >> 30) / 64'd21;
      localparam logic [63:0] T22 = ((T21 * Y) >> 30) / 64'd22;
      localparam logic [63:0] T23 = ((T22 * Y) >> 30) / 64'd23;
      localparam logic [63:0] T24 = ((T23 * Y) >> 30) / 64'd24;
      localparam logic [63:0] E0  = ONE - T01 + T02 - T03 + T04 - T05 + T06
                                    - T07 + T08 - T09 + T10 - T11 + T12 - T13
                                    + T14 - T15 + T16 - T17 + T18 - T19 + T20
                                    - T21 + T22 - T23 + T24;
      localparam logic [63:0] E1  = (E0 * E0 + avd_pkg::Q30_HALF) >> 30;
      localparam logic [63:0] E2  = (E1 * E1 + avd_pkg::Q30_HALF) >> 30;
      localparam logic [63:0] E3  = (E2 * E2 + avd_pkg::Q30_HALF) >> 30;
      localparam logic [63:0] E4  = (E3 * E3 + avd_pkg::Q30_HALF) >> 30;
      localparam logic [63:0] E5  = (E4 * E4 + avd_pkg::Q30_HALF) >> 30;
      localparam logic [63:0] DEN = ONE + E5;
      localparam logic [63:0] SAMPLE = ((ONE << 12) + (DEN >> 1)) / DEN;

      assign rom_table[k] = SAMPLE[avd_pkg::Q12_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= rom_table[addr_a];
         data_b_ff <= rom_table[addr_b];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/activation_value_and_derivative.sv =====
// An accepted input transaction reaches the response port through the pipeline stages in order.
// Throughput: one transaction per cycle unless the response channel stalls; the sigmoid table is read at two
// addresses in the same cycle, and each pipeline stage holds one item.
// Reset clears all stage valid flags and sets the function mode to linear.
// The sigmoid table is a constant memory and needs no clearing after reset.
`default_nettype none

`include "assert_macros.svh"

module activation_value_and_derivative #(
   parameter int TABLE_ENTRIES = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   avd_req_if.sink                            req_chan,
   avd_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_write_enable,
   input  wire logic [avd_pkg::MODE_W-1:0]    csr_write_data
);

   localparam int AW = $clog2(TABLE_ENTRIES + 1);
   localparam int QW = 17 + AW;
   localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES);

   avd_pkg::function_mode_type mode_ff;

   logic en1, en2, en3, en4, en5;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= avd_pkg::MODE_LINEAR;
      end else if (csr_write_enable) begin
         mode_ff <= avd_pkg::function_mode_type'(csr_write_data);
      end
   end

   assign en5 = !v5_ff || rsp_chan.ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_chan.valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
         if (en5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   // Table address: the magnitude of the argument scaled by the table size.
   logic signed [16:0] z_in;
   logic [16:0]        p_in;
   logic [QW-1:0]      q_in;
   logic [AW-1:0]      k_in;
   logic [AW-1:0]      addr_a;
   logic [AW-1:0]      addr_b;

   always_comb begin
      if (mode_ff == avd_pkg::MODE_TANH) begin
         z_in = {req_chan.pre_activation, 1'b0};
      end else begin
         z_in = {req_chan.pre_activation[15], req_chan.pre_activation};
      end
      p_in = z_in[16] ? 17'(-z_in) : 17'(z_in);
      q_in = QW'(p_in) * QW'(TABLE_ENTRIES);
      k_in = q_in[16 +: AW];
      if (k_in >= LAST) begin
         addr_a = LAST;
         addr_b = LAST;
      end else begin
         addr_a = k_in;
         addr_b = k_in + AW'(1);
      end
   end

   avd_pkg::q12_type rom_a;
   avd_pkg::q12_type rom_b;

   avd_sig_rom #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_sig_rom (
      .clock     (clock),
      .rd_en     (en1),
      .addr_a    (addr_a),
      .addr_b    (addr_b),
      .data_a_ff (rom_a),
      .data_b_ff (rom_b)
   );

   logic [15:0] x1_ff;
   logic [15:0] f1_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         x1_ff <= req_chan.pre_activation;
         f1_ff <= q_in[15:0];
      end
   end

   // Interpolation between the two neighboring samples.
   avd_pkg::q12_type d2;
   logic [29:0]      prod2;
   avd_pkg::q12_type inc2_in;
   avd_pkg::q12_type inc2_ff;
   avd_pkg::q12_type a2_ff;
   logic [15:0]      x2_ff;

   always_comb begin
      d2      = (rom_b >= rom_a) ? rom_b - rom_a : '0;
      prod2   = 30'(d2) * 30'(f1_ff) + 30'd32768;
      inc2_in = prod2[28:16];
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         inc2_ff <= inc2_in;
         a2_ff   <= rom_a;
         x2_ff   <= x1_ff;
      end
   end

   logic [13:0]      sum3;
   avd_pkg::q12_type sp3_in;
   avd_pkg::q12_type sp3_ff;
   logic [15:0]      x3_ff;

   always_comb begin
      sum3   = {1'b0, a2_ff} + {1'b0, inc2_ff};
      sp3_in = (sum3 > 14'(avd_pkg::Q12_ONE)) ? avd_pkg::Q12_ONE : sum3[12:0];
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         sp3_ff <= sp3_in;
         x3_ff  <= x2_ff;
      end
   end

   // Both derivative products are even in the sign of the argument, so their
   // operands come from the magnitude-side sample alone.
   avd_pkg::q12_type s_signed;
   logic [13:0]      two_sp;
   avd_pkg::q12_type m4;
   logic [15:0]      tanh_val;
   logic [15:0]      act4_in;
   avd_pkg::q12_type opa4_in;
   avd_pkg::q12_type opb4_in;
   logic [15:0]      act4_ff;
   avd_pkg::q12_type opa4_ff;
   avd_pkg::q12_type opb4_ff;
   logic             xneg4_ff;

   always_comb begin
      s_signed = x3_ff[15] ? avd_pkg::Q12_ONE - sp3_ff : sp3_ff;
      two_sp   = {sp3_ff, 1'b0};
      if (two_sp >= 14'(avd_pkg::Q12_ONE)) begin
         m4 = 13'(two_sp - 14'(avd_pkg::Q12_ONE));
      end else begin
         m4 = 13'(14'(avd_pkg::Q12_ONE) - two_sp);
      end
      tanh_val = {2'b00, s_signed, 1'b0} - 16'(avd_pkg::Q12_ONE);
      opa4_in  = '0;
      opb4_in  = '0;
      case (mode_ff)
         avd_pkg::MODE_STEP: begin
            act4_in = x3_ff[15] ? '0 : 16'(avd_pkg::Q12_ONE);
         end
         avd_pkg::MODE_LINEAR: begin
            act4_in = x3_ff;
         end
         avd_pkg::MODE_RELU: begin
            act4_in = x3_ff[15] ? '0 : x3_ff;
         end
         avd_pkg::MODE_SIGMOID: begin
            act4_in = 16'(s_signed);
            opa4_in = sp3_ff;
            opb4_in = avd_pkg::Q12_ONE - sp3_ff;
         end
         avd_pkg::MODE_TANH: begin
            act4_in = tanh_val;
            opa4_in = m4;
            opb4_in = m4;
         end
         default: begin
            act4_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         act4_ff  <= act4_in;
         opa4_ff  <= opa4_in;
         opb4_ff  <= opb4_in;
         xneg4_ff <= x3_ff[15];
      end
   end

   logic [25:0]                  prod5;
   avd_pkg::q12_type             rnd5;
   logic [avd_pkg::SLOPE_W-1:0]  slope5_in;
   logic [avd_pkg::SLOPE_W-1:0]  slope5_ff;
   logic [15:0]                  act5_ff;

   always_comb begin
      prod5 = 26'(opa4_ff) * 26'(opb4_ff) + 26'd2048;
      rnd5  = prod5[24:12];
      case (mode_ff)
         avd_pkg::MODE_STEP: begin
            slope5_in = '0;
         end
         avd_pkg::MODE_LINEAR: begin
            slope5_in = avd_pkg::Q12_ONE;
         end
         avd_pkg::MODE_RELU: begin
            slope5_in = xneg4_ff ? '0 : avd_pkg::Q12_ONE;
         end
         avd_pkg::MODE_SIGMOID: begin
            slope5_in = rnd5;
         end
         avd_pkg::MODE_TANH: begin
            slope5_in = avd_pkg::Q12_ONE - rnd5;
         end
         default: begin
            slope5_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         act5_ff   <= act4_ff;
         slope5_ff <= slope5_in;
      end
   end

   assign rsp_chan.valid      = v5_ff;
   assign rsp_chan.activation = act5_ff;
   assign rsp_chan.slope      = slope5_ff;

   `AVD_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !v1_ff && !v5_ff)
   `AVD_ASSERT(a_slope_range, clock, reset,
      v5_ff |-> slope5_ff <= avd_pkg::Q12_ONE)
   `AVD_ASSERT(a_sample_clamped, clock, reset,
      v3_ff |-> sp3_ff <= avd_pkg::Q12_ONE)
   `AVD_ASSERT(a_stage2_holds, clock, reset,
      v2_ff && !en3 |=> v2_ff && $stable(a2_ff) && $stable(inc2_ff))

endmodule

`default_nettype wire
